// ----- design/pooling_forward_max_avg_unit_macros.svh -----
// assertion macros shared by the pooling unit
`ifndef POOLING_FORWARD_MAX_AVG_UNIT_MACROS_SVH
`define POOLING_FORWARD_MAX_AVG_UNIT_MACROS_SVH

// implication checked on every clock edge outside reset
`define PFM_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("pooling assertion failed");

// next-cycle implication checked outside reset
`define PFM_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("pooling assertion failed");

`endif

// ----- design/pfm_pkg.sv -----
package pfm_pkg;
    localparam int CFG_W = 7;
    localparam int IDX_W = 3;
    // build limits of the feature store and the window
    localparam int MAX_CHANNELS = 16;
    localparam int MAX_ROWS     = 64;
    localparam int MAX_COLS     = 64;
    localparam int MAX_WINDOW   = 8;
    localparam logic [IDX_W-1:0] REG_CHANNEL_COUNT = 3'd0;
    localparam logic [IDX_W-1:0] REG_MAP_ROWS      = 3'd1;
    localparam logic [IDX_W-1:0] REG_MAP_COLS      = 3'd2;
    localparam logic [IDX_W-1:0] REG_WINDOW_ROWS   = 3'd3;
    localparam logic [IDX_W-1:0] REG_WINDOW_COLS   = 3'd4;
    localparam logic [IDX_W-1:0] REG_STEP_ROWS     = 3'd5;
    localparam logic [IDX_W-1:0] REG_STEP_COLS     = 3'd6;
    localparam logic [IDX_W-1:0] REG_POOL_KIND     = 3'd7;
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;
    localparam logic KIND_MAX   = 1'b0;
    localparam logic KIND_AVG   = 1'b1;

    // one classified command from front end to back end
    typedef struct packed {
        logic        is_query;
        logic        empty;
        logic [3:0]  chan;
        logic [8:0]  row0;    // first input row (write: the row)
        logic [8:0]  col0;
        logic [3:0]  nrows;   // clipped window rows
        logic [3:0]  ncols;
        logic [15:0] sample;
    } t_cmd;
endpackage

// ----- design/pfm_ram.sv -----
module pfm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- design/pfm_front.sv -----
module pfm_front import pfm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_mode,
    input  logic [3:0]  i_chan,
    input  logic [5:0]  i_row,
    input  logic [5:0]  i_col,
    input  logic [15:0] i_sample,
    input  logic [6:0]  i_nch,
    input  logic [6:0]  i_nr,
    input  logic [6:0]  i_nc,
    input  logic [3:0]  i_wr,
    input  logic [3:0]  i_wc,
    input  logic [3:0]  i_sr,
    input  logic [3:0]  i_sc,
    output logic        o_valid,
    input  logic        i_ready,
    output t_cmd        o_cmd
);
    // two-entry queue toward the back end
    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic [9:0] w_r0, w_c0, w_rr, w_cr;
    logic       w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_comb begin
        w_r0 = {4'd0, i_row} * {6'd0, i_sr};
        w_c0 = {4'd0, i_col} * {6'd0, i_sc};
        w_rr = ({3'd0, i_nr} > w_r0) ? ({3'd0, i_nr} - w_r0) : 10'd0;
        w_cr = ({3'd0, i_nc} > w_c0) ? ({3'd0, i_nc} - w_c0) : 10'd0;
        w_cmd.is_query = (i_mode == MODE_QUERY);
        w_cmd.chan   = i_chan;
        w_cmd.sample = i_sample;
        if (i_mode == MODE_QUERY) begin
            w_cmd.row0  = w_r0[8:0];
            w_cmd.col0  = w_c0[8:0];
            w_cmd.nrows = (w_rr < {6'd0, i_wr}) ? w_rr[3:0] : i_wr;
            w_cmd.ncols = (w_cr < {6'd0, i_wc}) ? w_cr[3:0] : i_wc;
            w_cmd.empty = ({3'd0, i_chan} >= i_nch) || (w_cmd.nrows == 4'd0)
                          || (w_cmd.ncols == 4'd0);
        end else begin
            w_cmd.row0  = {3'd0, i_row};
            w_cmd.col0  = {3'd0, i_col};
            w_cmd.nrows = 4'd1;
            w_cmd.ncols = 4'd1;
            // an out-of-map write is dropped
            w_cmd.empty = ({3'd0, i_chan} >= i_nch) || ({1'b0, i_row} >= i_nr)
                          || ({1'b0, i_col} >= i_nc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_cmd;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

// ----- design/pfm_divider.sv -----
module pfm_divider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [22:0] i_num,
    input  logic [6:0]         i_den,
    output logic               o_done,
    output logic [15:0]        o_quot
);
    // restoring division, one bit a cycle, sign applied at the end
    logic [22:0] r_rem, r_q;
    logic [4:0]  r_cnt;
    logic        r_busy, r_neg;
    logic [23:0] w_try;
    logic [22:0] w_nq;

    assign w_try = {r_rem, r_q[22]} - {17'd0, i_den};
    assign w_nq  = r_neg ? (~r_q + 23'd1) : r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd23;
                r_neg  <= i_num[22];
                r_q    <= i_num[22] ? (~i_num + 23'd1) : i_num;
                r_rem  <= 23'd0;
            end else if (r_busy) begin
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0; o_done <= 1'b1;
                    o_quot <= w_nq[15:0];
                end else begin
                    r_cnt <= r_cnt - 5'd1;
                    if (!w_try[23]) begin
                        r_rem <= w_try[22:0];
                        r_q   <= {r_q[21:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[21:0], r_q[22]};
                        r_q   <= {r_q[21:0], 1'b0};
                    end
                end
            end
        end
    end
endmodule

// ----- design/pfm_back.sv -----
module pfm_back import pfm_pkg::*; #(
    parameter int CH_W  = 4,
    parameter int ROW_W = 6,
    parameter int COL_W = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_cmd        i_cmd,
    input  logic        i_kind,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_value,
    output logic        o_empty
);
    `include "pooling_forward_max_avg_unit_macros.svh"
    localparam int AW = CH_W + ROW_W + COL_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001, S_READ = 5'b00010, S_TAIL = 5'b00100,
        S_DIV  = 5'b01000, S_OUT  = 5'b10000
    } t_state;

    t_state             r_st;
    t_cmd               r_cmd;
    logic [3:0]         r_dr, r_dc;
    logic               r_rdv, r_first;
    logic signed [15:0] r_best;
    logic signed [22:0] r_sum;
    logic [6:0]         r_count;
    logic [15:0]        w_rdata;
    logic [AW-1:0]      w_raddr, w_waddr;
    logic [8:0]         w_r, w_c;
    logic               w_last, w_we, w_dstart, w_ddone;
    logic [15:0]        w_quot;
    logic               w_take;

    assign w_r     = r_cmd.row0 + {5'd0, r_dr};
    assign w_c     = r_cmd.col0 + {5'd0, r_dc};
    assign w_raddr = {r_cmd.chan[CH_W-1:0], w_r[ROW_W-1:0], w_c[COL_W-1:0]};
    assign w_waddr = {i_cmd.chan[CH_W-1:0], i_cmd.row0[ROW_W-1:0],
                      i_cmd.col0[COL_W-1:0]};
    assign o_ready = (r_st == S_IDLE);
    assign w_take  = i_valid && o_ready;
    assign w_we    = w_take && !i_cmd.is_query && !i_cmd.empty;
    assign w_last  = (r_dr == r_cmd.nrows - 4'd1) && (r_dc == r_cmd.ncols - 4'd1);
    assign w_dstart = (r_st == S_TAIL) && !r_rdv && (i_kind == KIND_AVG) && !r_cmd.empty;
    assign o_valid = (r_st == S_OUT);

    pfm_ram #(.WIDTH(16), .DEPTH(1 << AW)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(i_cmd.sample),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    pfm_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart), .i_num(r_sum),
        .i_den(r_count), .o_done(w_ddone), .o_quot(w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (r_rdv) begin
            r_first <= 1'b0;
            if (r_first || $signed(w_rdata) > r_best) r_best <= $signed(w_rdata);
            r_sum   <= r_sum + {{7{w_rdata[15]}}, w_rdata};
            r_count <= r_count + 7'd1;
        end
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_rdv <= 1'b0;
        end else begin
            r_rdv <= 1'b0;
            unique case (r_st)
                S_IDLE: if (w_take && i_cmd.is_query) begin
                    r_cmd <= i_cmd; r_dr <= 4'd0; r_dc <= 4'd0;
                    r_first <= 1'b1; r_sum <= 23'd0; r_count <= 7'd0;
                    r_best <= 16'sd0;
                    r_st <= i_cmd.empty ? S_TAIL : S_READ;
                end
                S_READ: begin
                    r_rdv <= 1'b1;
                    if (w_last) r_st <= S_TAIL;
                    else if (r_dc == r_cmd.ncols - 4'd1) begin
                        r_dc <= 4'd0; r_dr <= r_dr + 4'd1;
                    end else r_dc <= r_dc + 4'd1;
                end
                S_TAIL: if (!r_rdv) begin
                    if (r_cmd.empty) begin
                        o_value <= 16'd0; o_empty <= 1'b1; r_st <= S_OUT;
                    end else if (i_kind == KIND_AVG) r_st <= S_DIV;
                    else begin
                        o_value <= r_best; o_empty <= 1'b0; r_st <= S_OUT;
                    end
                end
                S_DIV: if (w_ddone) begin
                    o_value <= w_quot; o_empty <= 1'b0; r_st <= S_OUT;
                end
                S_OUT: if (i_ready) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end

    `PFM_ASSERT_IMP(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, ##1 o_valid)
    `PFM_ASSERT_IMP(a_no_take_busy, i_clk, i_rst_n, r_st != S_IDLE, !w_we)
    `PFM_ASSERT_NXT(a_div_from_tail, i_clk, i_rst_n, w_dstart, r_st == S_DIV)
endmodule

// ----- design/pooling_forward_max_avg_unit.sv -----
// channel | dir | handshake              | payload
// s_axis  | in  | s_axis_tvalid/tready   | tuser mode, tdata chan,row,col,sample
// m_axis  | out | m_axis_tvalid/tready   | tuser empty_window, tdata pooled_value
// cfg     | in  | i_cfg_we               | i_cfg_index, i_cfg_data
// a write transaction passes through the queue; a query reads its
// clipped window one sample a cycle from the feature ram, and an average then goes
// through the bit-serial divider
// reset clears control only; the feature ram is undefined until written
// the front queue keeps accepting until its two entries are full while a result waits on m_axis_tready
module pooling_forward_max_avg_unit import pfm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // chan[3:0], row_pos[9:4], col_pos[15:10], sample[31:16]
    input  logic        s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // pooled_value
    output logic        m_axis_tuser,   // empty_window
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data
);
    localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    // configuration registers
    logic [4:0] r_chn;
    logic [6:0] r_rows, r_cols;
    logic [3:0] r_wr, r_wc, r_sr, r_sc;
    logic       r_kind;
    logic [6:0] w_nch, w_nr, w_nc;
    logic [3:0] w_wr, w_wc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chn <= 5'd1; r_rows <= 7'd64; r_cols <= 7'd64;
            r_wr <= 4'd2; r_wc <= 4'd2; r_sr <= 4'd2; r_sc <= 4'd2;
            r_kind <= KIND_MAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_CHANNEL_COUNT: r_chn  <= i_cfg_data[4:0];
                REG_MAP_ROWS:      r_rows <= i_cfg_data;
                REG_MAP_COLS:      r_cols <= i_cfg_data;
                REG_WINDOW_ROWS:   r_wr   <= i_cfg_data[3:0];
                REG_WINDOW_COLS:   r_wc   <= i_cfg_data[3:0];
                REG_STEP_ROWS:     r_sr   <= i_cfg_data[3:0];
                REG_STEP_COLS:     r_sc   <= i_cfg_data[3:0];
                REG_POOL_KIND:     r_kind <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // saturate at the build limits
    assign w_nch = ({2'd0, r_chn} > 7'(MAX_CHANNELS)) ? 7'(MAX_CHANNELS) : {2'd0, r_chn};
    assign w_nr  = (r_rows > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : r_rows;
    assign w_nc  = (r_cols > 7'(MAX_COLS)) ? 7'(MAX_COLS) : r_cols;
    assign w_wr  = (r_wr > 4'(MAX_WINDOW)) ? 4'(MAX_WINDOW) : r_wr;
    assign w_wc  = (r_wc > 4'(MAX_WINDOW)) ? 4'(MAX_WINDOW) : r_wc;

    t_cmd w_cmd;
    logic w_qvalid, w_qready;

    pfm_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_mode(s_axis_tuser), .i_chan(s_axis_tdata[3:0]),
        .i_row(s_axis_tdata[9:4]), .i_col(s_axis_tdata[15:10]),
        .i_sample(s_axis_tdata[31:16]),
        .i_nch(w_nch), .i_nr(w_nr), .i_nc(w_nc), .i_wr(w_wr), .i_wc(w_wc),
        .i_sr(r_sr), .i_sc(r_sc),
        .o_valid(w_qvalid), .i_ready(w_qready), .o_cmd(w_cmd)
    );

    pfm_back #(.CH_W(CH_W), .ROW_W(ROW_W), .COL_W(COL_W)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_qvalid), .o_ready(w_qready), .i_cmd(w_cmd), .i_kind(r_kind),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_value(m_axis_tdata), .o_empty(m_axis_tuser)
    );
endmodule
